>>> hdl/leb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pkg: shared definitions for the line edit buffer
// Edit command codes, cell commands, storage depth and derived widths.
// ----------------------------------------------------------------------------
package leb_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int CHAR_W     = 8;
   localparam int OP_W       = 4;
   localparam int LIMIT_W    = 7;
   localparam int LEN_OUT_W  = 7;
   localparam int POS_W      = $clog2(LINE_DEPTH + 1);
   localparam int CNT_W      = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
   localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0]  NO_CHAR      = 8'h00;

   localparam logic [OP_W-1:0] OP_INSERT    = 4'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 4'd1;
   localparam logic [OP_W-1:0] OP_DELETE    = 4'd2;
   localparam logic [OP_W-1:0] OP_LEFT      = 4'd3;
   localparam logic [OP_W-1:0] OP_RIGHT     = 4'd4;
   localparam logic [OP_W-1:0] OP_HOME      = 4'd5;
   localparam logic [OP_W-1:0] OP_END       = 4'd6;
   localparam logic [OP_W-1:0] OP_KILL      = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;
   localparam logic [OP_W-1:0] OP_ENTER     = 4'd9;

   typedef logic [1:0] cell_cmd_type;

   localparam cell_cmd_type CELL_HOLD       = 2'd0;
   localparam cell_cmd_type CELL_LOAD       = 2'd1;
   localparam cell_cmd_type CELL_FROM_LEFT  = 2'd2;
   localparam cell_cmd_type CELL_FROM_RIGHT = 2'd3;

   typedef struct packed {
      cell_cmd_type      cmd;
      logic [CHAR_W-1:0] load_char;
   } cell_ctl_type;

endpackage
`default_nettype wire

>>> hdl/line_edit_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An edit command other than enter completes in the cycle it is accepted; busy stays low.
// Enter holds busy while it emits its characters (0 to 64), one result a cycle.
// The first result is on the ports once busy is set and rsp_valid is registered; results cannot be stalled.
// One edit is taken per cycle while busy is low; enter streams the line by shifting the cell chain.
// Reset clears cursor, length, busy and the strobe and sets line_limit to 64.
// ----------------------------------------------------------------------------
// line_edit_buffer_unit: line editor built on a chain of character cells
// Applies edit transactions by shifting the cell chain and streams the line on enter.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [leb_pkg::OP_W-1:0]      req_op,
   input  wire logic [leb_pkg::CHAR_W-1:0]    req_ch,
   output logic                               rsp_valid,
   output logic      [leb_pkg::CHAR_W-1:0]    rsp_char_out,
   output logic      [leb_pkg::LEN_OUT_W-1:0] rsp_line_length,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [leb_pkg::LIMIT_W-1:0]   csr_wdata
);
   import leb_pkg::*;

   logic [LIMIT_W-1:0]   limit_ff;
   logic [CNT_W-1:0]     cursor_ff, cursor_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;

   logic [CNT_W-1:0]     eff_limit;
   logic [CNT_W-1:0]     lim_ext;
   logic                 accept;
   logic                 room;
   cell_ctl_type         ctl [LINE_DEPTH];
   logic [CHAR_W-1:0]    cell_char [LINE_DEPTH];

   assign accept    = start && !busy_ff;
   assign lim_ext   = CNT_W'(limit_ff);
   assign eff_limit = (lim_ext < CNT_W'(LINE_DEPTH)) ? lim_ext : CNT_W'(LINE_DEPTH);
   assign room      = len_ff < eff_limit;

   always_comb begin
      cursor_in    = cursor_ff;
      len_in       = len_ff;
      remain_in    = remain_ff;
      total_in     = total_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_char_in  = cell_char[0];
      for (int k = 0; k < LINE_DEPTH; k++) begin
         ctl[k].cmd       = CELL_HOLD;
         ctl[k].load_char = (req_op == OP_ENTER) ? NEWLINE_CHAR : req_ch;
      end
      if (busy_ff) begin
         for (int k = 0; k < LINE_DEPTH; k++) begin
            ctl[k].cmd = CELL_FROM_RIGHT;
         end
         rsp_valid_in = 1'b1;
         rsp_last_in  = (remain_ff == CNT_W'(1));
         remain_in    = remain_ff - CNT_W'(1);
         busy_in      = (remain_ff != CNT_W'(1));
      end else if (accept) begin
         case (req_op)
            OP_INSERT: begin
               if (req_ch != NO_CHAR && room) begin
                  for (int k = 0; k < LINE_DEPTH; k++) begin
                     if (CNT_W'(k) == cursor_ff) begin
                        ctl[k].cmd = CELL_LOAD;
                     end else if (CNT_W'(k) > cursor_ff) begin
                        ctl[k].cmd = CELL_FROM_LEFT;
                     end
                  end
                  cursor_in = cursor_ff + CNT_W'(1);
                  len_in    = len_ff + CNT_W'(1);
               end
            end
            OP_BACKSPACE: begin
               if (cursor_ff != '0) begin
                  for (int k = 0; k < LINE_DEPTH; k++) begin
                     if (CNT_W'(k) >= cursor_ff - CNT_W'(1)) begin
                        ctl[k].cmd = CELL_FROM_RIGHT;
                     end
                  end
                  cursor_in = cursor_ff - CNT_W'(1);
                  len_in    = len_ff - CNT_W'(1);
               end
            end
            OP_DELETE: begin
               if (cursor_ff < len_ff) begin
                  for (int k = 0; k < LINE_DEPTH; k++) begin
                     if (CNT_W'(k) >= cursor_ff) begin
                        ctl[k].cmd = CELL_FROM_RIGHT;
                     end
                  end
                  len_in = len_ff - CNT_W'(1);
               end
            end
            OP_LEFT: begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - CNT_W'(1);
               end
            end
            OP_RIGHT: begin
               if (cursor_ff < len_ff) begin
                  cursor_in = cursor_ff + CNT_W'(1);
               end
            end
            OP_HOME:  cursor_in = '0;
            OP_END:   cursor_in = len_ff;
            OP_KILL:  len_in    = cursor_ff;
            OP_CLEAR: begin
               cursor_in = '0;
               len_in    = '0;
            end
            OP_ENTER: begin
               total_in = len_ff;
               if (room) begin
                  for (int k = 0; k < LINE_DEPTH; k++) begin
                     if (CNT_W'(k) == len_ff) begin
                        ctl[k].cmd = CELL_LOAD;
                     end
                  end
                  total_in = len_ff + CNT_W'(1);
               end
               remain_in = total_in;
               busy_in   = (total_in != '0);
               cursor_in = '0;
               len_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
      logic [CHAR_W-1:0] left_char;
      logic [CHAR_W-1:0] right_char;
      if (g == 0) begin : g_first
         assign left_char = NO_CHAR;
      end else begin : g_inner_l
         assign left_char = cell_char[g-1];
      end
      if (g == LINE_DEPTH - 1) begin : g_lastc
         assign right_char = NO_CHAR;
      end else begin : g_inner_r
         assign right_char = cell_char[g+1];
      end
      leb_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .left_char  (left_char),
         .right_char (right_char),
         .char_q     (cell_char[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         cursor_ff    <= '0;
         len_ff       <= '0;
         remain_ff    <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
         cursor_ff    <= cursor_in;
         len_ff       <= len_in;
         remain_ff    <= remain_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign busy            = busy_ff;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_line_length = LEN_OUT_W'(total_ff);
   assign rsp_last        = rsp_last_ff;

   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= len_ff)
      else $error("cursor beyond line length");

   a_len_in_store: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(LINE_DEPTH))
      else $error("line length beyond store depth");

   a_idle_no_remain: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> remain_ff == '0)
      else $error("characters pending while idle");

   a_final_char: assert property (@(posedge clock) disable iff (reset)
      busy_ff && remain_ff == CNT_W'(1) |=> !busy_ff && rsp_valid_ff && rsp_last_ff)
      else $error("final character not marked last");

   a_last_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_valid_ff)
      else $error("last flag without strobe");

endmodule
`default_nettype wire

>>> hdl/leb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb_cell: one character cell of the line chain
// Holds one character; loads a new one or takes its left or right neighbor's.
// ----------------------------------------------------------------------------
module leb_cell (
   input  wire logic                       clock,
   input  wire leb_pkg::cell_ctl_type      ctl,
   input  wire logic [leb_pkg::CHAR_W-1:0] left_char,
   input  wire logic [leb_pkg::CHAR_W-1:0] right_char,
   output logic      [leb_pkg::CHAR_W-1:0] char_q
);
   import leb_pkg::*;

   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;

   always_comb begin
      case (ctl.cmd)
         CELL_LOAD:       char_in = ctl.load_char;
         CELL_FROM_LEFT:  char_in = left_char;
         CELL_FROM_RIGHT: char_in = right_char;
         default:         char_in = char_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_q = char_ff;

endmodule
`default_nettype wire

>>> tb/line_edit_buffer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer_unit_tb: self-checking bench for the line edit buffer
// Drives edit transactions with random gaps and predicts each line emitted on
// enter. Every streamed character is checked against the predicted line across
// several line_limit settings, the extremes among them.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit_tb;
   import leb_pkg::*;

   localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

   typedef struct {
      logic [CHAR_W-1:0]    ch;
      logic [LEN_OUT_W-1:0] total;
      logic                 last;
   } line_char_type;

   class line_checker;
      logic [CHAR_W-1:0] text [LINE_DEPTH];
      int unsigned       cursor;
      int unsigned       length;
      int unsigned       limit;
      line_char_type     emitted_q [$];
      int                errors;
      int                compared;

      function new();
         foreach (text[i]) text[i] = NO_CHAR;
         cursor   = 0;
         length   = 0;
         limit    = 64;
         errors   = 0;
         compared = 0;
      endfunction

      function void remove_at(int unsigned pos);
         for (int unsigned k = pos; k + 1 < length; k++) text[k] = text[k + 1];
         length--;
      endfunction

      function void apply_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
         int unsigned   eff;
         int unsigned   total;
         line_char_type item;
         eff = (limit < LINE_DEPTH) ? limit : LINE_DEPTH;
         case (op)
            OP_INSERT: begin
               if (ch != NO_CHAR && length < eff) begin
                  for (int unsigned k = length; k > cursor; k--) text[k] = text[k - 1];
                  text[cursor] = ch;
                  length++;
                  cursor++;
               end
            end
            OP_BACKSPACE: begin
               if (cursor > 0) begin
                  cursor--;
                  remove_at(cursor);
               end
            end
            OP_DELETE: if (cursor < length) remove_at(cursor);
            OP_LEFT:   if (cursor > 0) cursor--;
            OP_RIGHT:  if (cursor < length) cursor++;
            OP_HOME:   cursor = 0;
            OP_END:    cursor = length;
            OP_KILL:   length = cursor;
            OP_CLEAR: begin
               length = 0;
               cursor = 0;
            end
            OP_ENTER: begin
               total = length;
               if (length < eff) begin
                  text[length] = NEWLINE_CHAR;
                  total++;
               end
               for (int unsigned k = 0; k < total; k++) begin
                  item.ch    = text[k];
                  item.total = LEN_OUT_W'(total);
                  item.last  = (k + 1 == total);
                  emitted_q.push_back(item);
               end
               length = 0;
               cursor = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_char(logic [CHAR_W-1:0] ch, logic [LEN_OUT_W-1:0] total,
                               logic last);
         line_char_type exp;
         compared++;
         if (emitted_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected character: got %h length %0d last %b", ch, total, last);
            return;
         end
         exp = emitted_q.pop_front();
         if (exp.ch !== ch || exp.total !== total || exp.last !== last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: char exp %h got %h, length exp %0d got %0d, last exp %b got %b",
                        exp.ch, ch, exp.total, total, exp.last, last);
         end
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   logic [OP_W-1:0]      req_op    = OP_CLEAR;
   logic [CHAR_W-1:0]    req_ch    = NO_CHAR;
   logic                 rsp_valid;
   logic [CHAR_W-1:0]    rsp_char_out;
   logic [LEN_OUT_W-1:0] rsp_line_length;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [LIMIT_W-1:0]   csr_wdata = LIMIT_RESET;

   line_checker editor = new();
   bit          steady = 1'b0;
   int          sent   = 0;
   int          writes = 0;

   line_edit_buffer_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_char_out    (rsp_char_out),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) editor.check_char(rsp_char_out, rsp_line_length, rsp_last);
   end

   task automatic send_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= op;
      req_ch <= ch;
      start  <= 1'b1;
      do @(posedge clock); while (busy);
      editor.apply_edit(op, ch);
      sent++;
   endtask

   // hold off until the line stream has drained and the block is idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (editor.emitted_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      settle();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      editor.limit = value;
      writes++;
   endtask

   task automatic fill_line();
      repeat (LINE_DEPTH + 2) send_edit(OP_INSERT, CHAR_W'($urandom_range(1, 255)));
      send_edit(OP_ENTER, CHAR_W'($urandom));
   endtask

   task automatic random_edit();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         send_edit(OP_INSERT, NO_CHAR);
      else if (pick < 50)
         send_edit(OP_INSERT, CHAR_W'($urandom_range(1, 255)));
      else if (pick < 82)
         send_edit(OP_W'($urandom_range(OP_BACKSPACE, OP_CLEAR)), CHAR_W'($urandom));
      else if (pick < 95)
         send_edit(OP_ENTER, CHAR_W'($urandom));
      else
         send_edit(OP_W'($urandom_range(OP_ENTER + 1, OP_LAST_CODE)), CHAR_W'($urandom));
   endtask

   initial begin
      logic [LIMIT_W-1:0] limit_plan [8];
      limit_plan = '{7'd1, 7'd2, 7'd7, 7'd127, 7'd64, 7'd63, 7'd20, 7'd0};
      limit_plan[7] = LIMIT_W'($urandom_range(1, 62));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge cases at the reset limit
      send_edit(OP_ENTER, NO_CHAR);
      send_edit(OP_INSERT, NO_CHAR);
      send_edit(OP_INSERT, 8'h41);
      send_edit(OP_INSERT, 8'hFF);
      send_edit(OP_INSERT, 8'h01);
      send_edit(OP_LEFT, 8'h00);
      send_edit(OP_LEFT, 8'hFF);
      send_edit(OP_BACKSPACE, 8'h55);
      send_edit(OP_DELETE, 8'hAA);
      send_edit(OP_HOME, 8'h00);
      send_edit(OP_LEFT, 8'h00);
      send_edit(OP_BACKSPACE, 8'h00);
      send_edit(OP_END, 8'h00);
      send_edit(OP_RIGHT, 8'h00);
      send_edit(OP_DELETE, 8'h00);
      send_edit(OP_INSERT, 8'h80);
      send_edit(OP_HOME, 8'h00);
      send_edit(OP_INSERT, 8'h7F);
      send_edit(OP_RIGHT, 8'h00);
      send_edit(OP_KILL, 8'h00);
      send_edit(OP_ENTER, 8'h00);
      send_edit(OP_ENTER + 4'd1, 8'h41);
      send_edit(OP_LAST_CODE, 8'hFF);
      send_edit(OP_INSERT, 8'h30);
      send_edit(OP_CLEAR, 8'h00);
      send_edit(OP_ENTER, 8'h00);

      // full line at the store depth, no newline
      fill_line();

      // lower the limit under the current length
      repeat (10) send_edit(OP_INSERT, CHAR_W'($urandom_range(1, 255)));
      write_limit(7'd5);
      send_edit(OP_INSERT, 8'h42);
      send_edit(OP_ENTER, 8'h00);

      // zero limit: inserts refused, enter emits nothing
      write_limit(7'd0);
      send_edit(OP_INSERT, 8'h7A);
      send_edit(OP_ENTER, 8'h00);
      repeat (10) random_edit();

      foreach (limit_plan[p]) begin
         write_limit(limit_plan[p]);
         if (limit_plan[p] >= 7'd63) fill_line();
         for (int i = 0; i < 20; i++) begin
            if (i % 12 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 31) == 0) settle();
            random_edit();
         end
      end
      steady = 1'b0;

      settle();
      repeat (8) @(posedge clock);
      $display("Summary: %0d edit transactions, %0d line characters compared, %0d limit writes",
               sent, editor.compared, writes);
      if (editor.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
